// ----- sv/twhl_pkg.sv -----
// shared types and constants for the two-wire handshake link
package twhl_pkg;

  localparam int unsigned WORD_BITS_DEFAULT = 8;
  localparam int unsigned BYTE_BITS = 8;

  typedef struct packed {
    logic                 line_zero_high;
    logic                 line_one_high;
    logic                 send_request;
    logic [BYTE_BITS-1:0] send_byte;
  } item_t;

  typedef struct packed {
    logic                 pull_zero_low;
    logic                 pull_one_low;
    logic                 received_valid;
    logic [BYTE_BITS-1:0] received_byte;
    logic                 send_done;
    logic                 busy_res;
    logic                 line_error;
  } result_t;

endpackage

// ----- sv/two_wire_handshake_link_top.sv -----
// two-wire handshake link: line handshake state machine with output buffering
//
// Usage: each transaction on the item channel carries one sample of both
// open-drain lines plus a send request and the word to send. The block
// updates its send/receive state machine once per item and returns exactly
// one result transaction: the line drives after the update, received word
// and done/error pulses, and a busy flag.
// Words go least significant bit first, WORD_BITS bits each.
// The result for an item is registered, in the result register or in the
// skid entry. Throughput: one item per cycle while item_ready is high, set
// by the single state update between the item and the result register.
// Stalls: a result register and one skid entry sit on the result side, so
// one more item is taken while a result waits; item_ready drops only when
// both hold results that the receiver has not taken.
// Reset (rst, synchronous, active high): state machine idle, both lines
// released, shift register and bit count cleared, buffers emptied.
// A stalled line partner leaves the block waiting without timeout.
module two_wire_handshake_link_top #(
  parameter int unsigned WORD_BITS = twhl_pkg::WORD_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  twhl_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output twhl_pkg::result_t result
);
  import twhl_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_BITS + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TX_ACK,
    PH_TX_RISE,
    PH_TX_FREE,
    PH_RX_RELEASE,
    PH_RX_START
  } phase_t;

  phase_t               phase, phase_next;
  logic [WORD_BITS-1:0] shift_reg, shift_reg_next;
  logic [CntW-1:0]      bits_done, bits_done_next;
  logic                 current_bit, current_bit_next;
  logic                 drive_zero, drive_zero_next;
  logic                 drive_one, drive_one_next;

  result_t res_next;
  result_t skid;
  logic    skid_valid;

  logic item_fire, result_fire;
  logic z, o;
  logic rvalid, sdone, err;
  logic [CntW-1:0] bits_inc;
  logic [WORD_BITS-1:0] shifted;
  logic [WORD_BITS+BYTE_BITS-1:0] load_pad;
  logic [WORD_BITS+BYTE_BITS-1:0] recv_pad;

  assign item_ready  = !skid_valid;
  assign item_fire   = item_valid && item_ready;
  assign result_fire = result_valid && result_ready;

  assign z        = item.line_zero_high;
  assign o        = item.line_one_high;
  assign bits_inc = bits_done + CntW'(1);
  assign shifted  = shift_reg >> 1;
  assign load_pad = {{WORD_BITS{1'b0}}, item.send_byte};

  always_comb begin
    phase_next       = phase;
    shift_reg_next   = shift_reg;
    bits_done_next   = bits_done;
    current_bit_next = current_bit;
    drive_zero_next  = drive_zero;
    drive_one_next   = drive_one;
    rvalid           = 1'b0;
    sdone            = 1'b0;
    err              = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (z && o) begin
          if (item.send_request) begin
            shift_reg_next   = load_pad[WORD_BITS-1:0];
            bits_done_next   = '0;
            current_bit_next = load_pad[0];
            drive_one_next   = load_pad[0];
            drive_zero_next  = !load_pad[0];
            phase_next       = PH_TX_ACK;
          end
        end else begin
          shift_reg_next = '0;
          bits_done_next = '0;
          if (z) begin
            current_bit_next = 1'b1;
            drive_zero_next  = 1'b1;
            phase_next       = PH_RX_RELEASE;
          end else if (o) begin
            current_bit_next = 1'b0;
            drive_one_next   = 1'b1;
            phase_next       = PH_RX_RELEASE;
          end else begin
            err = 1'b1;
          end
        end
      end
      PH_TX_FREE: begin
        if (z && o) begin
          current_bit_next = shift_reg[0];
          drive_one_next   = shift_reg[0];
          drive_zero_next  = !shift_reg[0];
          phase_next       = PH_TX_ACK;
        end
      end
      PH_TX_ACK: begin
        if (!(current_bit ? z : o)) begin
          drive_zero_next = 1'b0;
          drive_one_next  = 1'b0;
          phase_next      = PH_TX_RISE;
        end
      end
      PH_TX_RISE: begin
        if (current_bit ? z : o) begin
          shift_reg_next = shifted;
          if (bits_inc >= CntW'(WORD_BITS)) begin
            sdone          = 1'b1;
            bits_done_next = '0;
            phase_next     = PH_IDLE;
          end else begin
            bits_done_next = bits_inc;
            phase_next     = PH_TX_FREE;
          end
        end
      end
      PH_RX_RELEASE: begin
        if (current_bit ? o : z) begin
          drive_zero_next                 = 1'b0;
          drive_one_next                  = 1'b0;
          shift_reg_next                  = shifted;
          shift_reg_next[WORD_BITS-1]     = current_bit;
          if (bits_inc >= CntW'(WORD_BITS)) begin
            rvalid         = 1'b1;
            bits_done_next = '0;
            phase_next     = PH_IDLE;
          end else begin
            bits_done_next = bits_inc;
            phase_next     = PH_RX_START;
          end
        end
      end
      PH_RX_START: begin
        if (z && !o) begin
          current_bit_next = 1'b1;
          drive_zero_next  = 1'b1;
          phase_next       = PH_RX_RELEASE;
        end else if (!z && o) begin
          current_bit_next = 1'b0;
          drive_one_next   = 1'b1;
          phase_next       = PH_RX_RELEASE;
        end else if (!z && !o) begin
          err            = 1'b1;
          shift_reg_next = '0;
          bits_done_next = '0;
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        shift_reg_next   = '0;
        bits_done_next   = '0;
        current_bit_next = 1'b0;
        drive_zero_next  = 1'b0;
        drive_one_next   = 1'b0;
      end
    endcase
    if (err) begin
      drive_zero_next = 1'b0;
      drive_one_next  = 1'b0;
      phase_next      = PH_IDLE;
    end
  end

  assign recv_pad = {{BYTE_BITS{1'b0}}, shift_reg_next};

  always_comb begin
    res_next.pull_zero_low  = drive_zero_next;
    res_next.pull_one_low   = drive_one_next;
    res_next.received_valid = rvalid;
    res_next.received_byte  = rvalid ? recv_pad[BYTE_BITS-1:0] : '0;
    res_next.send_done      = sdone;
    res_next.busy_res       = (phase_next != PH_IDLE);
    res_next.line_error     = err;
  end

  // state update and result buffering
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      shift_reg    <= '0;
      bits_done    <= '0;
      current_bit  <= 1'b0;
      drive_zero   <= 1'b0;
      drive_one    <= 1'b0;
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (item_fire) begin
        phase       <= phase_next;
        shift_reg   <= shift_reg_next;
        bits_done   <= bits_done_next;
        current_bit <= current_bit_next;
        drive_zero  <= drive_zero_next;
        drive_one   <= drive_one_next;
        if (result_valid && !result_ready) begin
          skid       <= res_next;
          skid_valid <= 1'b1;
        end else begin
          result       <= res_next;
          result_valid <= 1'b1;
        end
      end else if (result_fire) begin
        if (skid_valid) begin
          result     <= skid;
          skid_valid <= 1'b0;
        end else begin
          result_valid <= 1'b0;
        end
      end
    end
  end

  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held without a result on the output");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (!drive_zero && !drive_one))
    else $error("line still driven in idle");

  a_single_drive: assert property (@(posedge clk) disable iff (rst)
    !(drive_zero && drive_one))
    else $error("both lines driven low");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (item_fire && result_valid && !result_ready) |=> skid_valid)
    else $error("transaction lost while result stalled");

endmodule

// ----- test/tb_two_wire_handshake_link_top.sv -----
// self-checking testbench for the two-wire handshake link, with a line partner model and scoreboard
module tb_two_wire_handshake_link_top;
  import twhl_pkg::*;

  localparam int unsigned WB = WORD_BITS_DEFAULT;
  localparam logic [31:0] WORD_MASK = (WB >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WB) - 32'd1);
  localparam int RANDOM_ITEMS = 650;
  localparam int PAUSE_AT = 320;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    LINK_IDLE,
    LINK_TX_ACK,
    LINK_TX_RISE,
    LINK_TX_FREE,
    LINK_RX_RELEASE,
    LINK_RX_START
  } link_phase_t;

  typedef enum logic [1:0] {
    PEER_QUIET,
    PEER_ACK,
    PEER_TX_PULL,
    PEER_TX_WAIT
  } peer_mode_t;

  class link_scoreboard;
    link_phase_t phase;
    logic [31:0] shreg;
    int unsigned bits_done;
    logic        cur_bit;
    logic        drv_zero;
    logic        drv_one;
    result_t     expected_results[$];
    int          errors;
    int          samples;
    int          words_sent;
    int          words_received;
    int          line_errors;

    function new();
      phase = LINK_IDLE;
      shreg = '0;
      bits_done = 0;
      cur_bit = 1'b0;
      drv_zero = 1'b0;
      drv_one = 1'b0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void load_bit();
      cur_bit = shreg[0];
      drv_one = cur_bit;
      drv_zero = !cur_bit;
      phase = LINK_TX_ACK;
    endfunction

    // returns 0 when both lines are low
    function bit start_rx_bit(input logic z, input logic o);
      if (z && !o) begin
        cur_bit = 1'b1;
        drv_zero = 1'b1;
        phase = LINK_RX_RELEASE;
      end else if (!z && o) begin
        cur_bit = 1'b0;
        drv_one = 1'b1;
        phase = LINK_RX_RELEASE;
      end else if (!z && !o) begin
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(input item_t it);
      result_t r;
      logic    z;
      logic    o;
      logic    other;
      logic    err;
      z = it.line_zero_high;
      o = it.line_one_high;
      r = '0;
      err = 1'b0;
      samples++;
      case (phase)
        LINK_IDLE: begin
          if (z && o) begin
            if (it.send_request) begin
              shreg = {24'd0, it.send_byte} & WORD_MASK;
              bits_done = 0;
              load_bit();
            end
          end else begin
            shreg = '0;
            bits_done = 0;
            err = !start_rx_bit(z, o);
          end
        end
        LINK_TX_FREE: begin
          if (z && o) load_bit();
        end
        LINK_TX_ACK: begin
          other = cur_bit ? z : o;
          if (!other) begin
            drv_zero = 1'b0;
            drv_one = 1'b0;
            phase = LINK_TX_RISE;
          end
        end
        LINK_TX_RISE: begin
          other = cur_bit ? z : o;
          if (other) begin
            shreg = shreg >> 1;
            bits_done++;
            if (bits_done >= WB) begin
              r.send_done = 1'b1;
              bits_done = 0;
              phase = LINK_IDLE;
              words_sent++;
            end else begin
              phase = LINK_TX_FREE;
            end
          end
        end
        LINK_RX_RELEASE: begin
          other = cur_bit ? o : z;
          if (other) begin
            drv_zero = 1'b0;
            drv_one = 1'b0;
            shreg = ((shreg >> 1) | (32'(cur_bit) << (WB - 1))) & WORD_MASK;
            bits_done++;
            if (bits_done >= WB) begin
              r.received_valid = 1'b1;
              r.received_byte = shreg[7:0];
              bits_done = 0;
              phase = LINK_IDLE;
              words_received++;
            end else begin
              phase = LINK_RX_START;
            end
          end
        end
        LINK_RX_START: begin
          if (!start_rx_bit(z, o)) begin
            err = 1'b1;
            phase = LINK_IDLE;
            shreg = '0;
            bits_done = 0;
          end
        end
        default: begin
          phase = LINK_IDLE;
          shreg = '0;
          bits_done = 0;
          cur_bit = 1'b0;
          drv_zero = 1'b0;
          drv_one = 1'b0;
        end
      endcase
      if (err) begin
        drv_zero = 1'b0;
        drv_one = 1'b0;
        phase = LINK_IDLE;
        line_errors++;
      end
      r.pull_zero_low = drv_zero;
      r.pull_one_low = drv_one;
      r.busy_res = (phase != LINK_IDLE);
      r.line_error = err;
      expected_results.push_back(r);
    endfunction

    task compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(input result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report("result transaction with no expectation waiting");
      end else begin
        want = expected_results.pop_front();
        compare_field("pull_zero_low", 8'(got.pull_zero_low), 8'(want.pull_zero_low));
        compare_field("pull_one_low", 8'(got.pull_one_low), 8'(want.pull_one_low));
        compare_field("received_valid", 8'(got.received_valid), 8'(want.received_valid));
        compare_field("received_byte", got.received_byte, want.received_byte);
        compare_field("send_done", 8'(got.send_done), 8'(want.send_done));
        compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        compare_field("line_error", 8'(got.line_error), 8'(want.line_error));
      end
    endtask
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  link_scoreboard sb;
  bit          burst = 1'b0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          ready_gap = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;

  peer_mode_t  peer_mode = PEER_QUIET;
  logic        peer_pull_zero = 1'b0;
  logic        peer_pull_one = 1'b0;
  logic [31:0] peer_word = '0;
  int unsigned peer_bit = 0;
  int          peer_delay = 0;
  int          peer_stall = 0;

  two_wire_handshake_link_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || hold_left > 0) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void pull_peer_bit();
    peer_pull_one = peer_word[peer_bit];
    peer_pull_zero = !peer_word[peer_bit];
    peer_mode = PEER_TX_PULL;
  endfunction

  // partner on the far end of the lines, reacting to the predicted drives of the link
  function automatic item_t next_line_item();
    item_t      it;
    peer_mode_t prev;
    int         r;
    prev = peer_mode;
    if (peer_delay > 0) begin
      peer_delay--;
    end else begin
      case (peer_mode)
        PEER_QUIET: begin
          if (sb.drv_zero || sb.drv_one) begin
            peer_pull_zero = sb.drv_one;
            peer_pull_one = sb.drv_zero;
            peer_mode = PEER_ACK;
          end else if (sb.phase == LINK_IDLE && $urandom_range(0, 3) == 0) begin
            peer_word = $urandom;
            peer_bit = 0;
            pull_peer_bit();
          end
        end
        PEER_ACK: begin
          if (!sb.drv_zero && !sb.drv_one) begin
            peer_pull_zero = 1'b0;
            peer_pull_one = 1'b0;
            peer_mode = PEER_QUIET;
          end
        end
        PEER_TX_PULL: begin
          if (peer_word[peer_bit] ? sb.drv_zero : sb.drv_one) begin
            peer_pull_zero = 1'b0;
            peer_pull_one = 1'b0;
            peer_mode = PEER_TX_WAIT;
          end
        end
        default: begin
          if (!sb.drv_zero && !sb.drv_one) begin
            peer_bit++;
            if (peer_bit >= WB) peer_mode = PEER_QUIET;
            else pull_peer_bit();
          end
        end
      endcase
    end
    if (peer_mode != prev) begin
      peer_stall = 0;
      peer_delay = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 3);
    end else begin
      peer_stall++;
      if (peer_stall > 24) begin
        // partner gives up on a stuck exchange
        peer_pull_zero = 1'b0;
        peer_pull_one = 1'b0;
        peer_mode = PEER_QUIET;
        peer_stall = 0;
      end
    end
    it.line_zero_high = !(sb.drv_zero || peer_pull_zero);
    it.line_one_high = !(sb.drv_one || peer_pull_one);
    r = $urandom_range(0, 99);
    it.send_request = (peer_mode == PEER_QUIET) ? (r < 20) : (r < 5);
    r = $urandom_range(0, 99);
    if (r < 10) it.send_byte = 8'h00;
    else if (r < 20) it.send_byte = 8'hFF;
    else it.send_byte = 8'($urandom);
    if ($urandom_range(0, 11) == 0) begin
      it.line_zero_high = 1'($urandom);
      it.line_one_high = 1'($urandom);
      it.send_request = 1'($urandom);
    end else if ((sb.phase == LINK_IDLE || sb.phase == LINK_RX_START) &&
                 $urandom_range(0, 39) == 0) begin
      it.line_zero_high = 1'b0;
      it.line_one_high = 1'b0;
    end
    return it;
  endfunction

  task automatic offer(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic offer_levels(input logic z, input logic o, input logic req,
                              input logic [7:0] data);
    item_t it;
    it.line_zero_high = z;
    it.line_one_high = o;
    it.send_request = req;
    it.send_byte = data;
    offer(it);
  endtask

  initial begin
    int n;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle, both-low error, receive with ignored request, error at bit start
    offer_levels(1'b1, 1'b1, 1'b0, 8'h00);
    offer_levels(1'b0, 1'b0, 1'b1, 8'hFF);
    offer_levels(1'b0, 1'b1, 1'b1, 8'h55);
    offer_levels(1'b0, 1'b0, 1'b0, 8'h00);
    offer_levels(1'b1, 1'b1, 1'b0, 8'h00);
    offer_levels(1'b0, 1'b0, 1'b0, 8'hFF);
    offer_levels(1'b1, 1'b0, 1'b0, 8'h00);
    offer_levels(1'b1, 1'b1, 1'b0, 8'h00);
    offer_levels(1'b1, 1'b1, 1'b0, 8'h00);
    offer_levels(1'b0, 1'b0, 1'b0, 8'h00);
    // send start, request while busy, both low while waiting to send
    offer_levels(1'b1, 1'b1, 1'b1, 8'hFF);
    offer_levels(1'b1, 1'b1, 1'b1, 8'h00);
    offer_levels(1'b0, 1'b1, 1'b0, 8'h00);
    offer_levels(1'b1, 1'b1, 1'b0, 8'h00);
    offer_levels(1'b0, 1'b0, 1'b0, 8'h00);
    offer_levels(1'b1, 1'b1, 1'b0, 8'h00);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PAUSE_AT) begin
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      burst = (((n / 64) % 4) == 2);
      offer(next_line_item());
    end
    item_valid <= 1'b0;
    burst = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected results left over at the end");

    $display("run covered %0d line samples and %0d result transactions",
             sb.samples, results_seen);
    $display("words sent %0d, words received %0d, line errors %0d",
             sb.words_sent, sb.words_received, sb.line_errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 120;
      result_ready <= 1'b0;
    end else if (burst) begin
      result_ready <= 1'b1;
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      result_ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:7]: begin
          ready_gap <= $urandom_range(1, 3);
          result_ready <= 1'b0;
        end
        [8:9]: begin
          ready_gap <= $urandom_range(10, 40);
          result_ready <= 1'b0;
        end
        default: result_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      results_seen <= results_seen + 1;
      sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
